// ===== rtl/aect_pkg.sv =====
// Package for the ANSI escape chunk tokenizer: widths, character codes,
// parser mode type, result struct and the CSI final-byte check. No dependencies.
package aect_pkg;

    localparam int LINE_BITS = 16;
    localparam int LINE_OUT_BITS = 16;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CSI  = 8'h5B;
    localparam logic [7:0] CH_OSC  = 8'h5D;
    localparam logic [7:0] CH_SGR  = 8'h6D;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2,
        MODE_OSC    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        LEN_EMPTY = 2'd0,
        LEN_ONE   = 2'd1,
        LEN_MANY  = 2'd2
    } t_len;

    typedef struct packed {
        logic                     append_valid;
        logic [7:0]               append_char;
        logic                     chunk_closed;
        logic                     closed_is_text;
        logic                     closed_is_reset;
        logic                     closed_is_title;
        logic                     closed_at_eol;
        logic [LINE_OUT_BITS-1:0] closed_line;
    } t_result;

    function automatic logic is_csi_final(input logic [7:0] c);
        logic hit;
        begin
            unique case (c)
                "K", "A", "B", "C", "D", "E", "F", "G", "H", "J",
                "S", "T", "f", "i", "n", "u", "s": hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

// ===== rtl/ansi_escape_chunk_tokenizer.sv =====
// Top level of the ANSI escape chunk tokenizer: input register, parser step
// and result register. Depends on aect_pkg and aect_parser.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------
//  input   | i_valid | o_ready | i_data_char
//  result  | o_valid | i_ready | o_append_*, o_chunk_closed, o_closed_*
//
// One character per cycle while the result side is not stalled; each beat gives
// one result after it passes the input register, then the result register.
// The parser step is a single combinational pass between the two registers.
// Synchronous active-low reset empties both registers and restores the parser.
// A stalled result holds the step; the input register still takes one beat.
module ansi_escape_chunk_tokenizer import aect_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_data_char,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_append_valid,
    output logic [7:0]               o_append_char,
    output logic                     o_chunk_closed,
    output logic                     o_closed_is_text,
    output logic                     o_closed_is_reset,
    output logic                     o_closed_is_title,
    output logic                     o_closed_at_eol,
    output logic [LINE_OUT_BITS-1:0] o_closed_line
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_result;
    logic       advance;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    aect_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_char   (r_in_char),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in_char <= i_data_char;
        if (advance) r_out <= step_result;
    end

    assign o_valid           = r_out_valid;
    assign o_append_valid    = r_out.append_valid;
    assign o_append_char     = r_out.append_char;
    assign o_chunk_closed    = r_out.chunk_closed;
    assign o_closed_is_text  = r_out.closed_is_text;
    assign o_closed_is_reset = r_out.closed_is_reset;
    assign o_closed_is_title = r_out.closed_is_title;
    assign o_closed_at_eol   = r_out.closed_at_eol;
    assign o_closed_line     = r_out.closed_line;

endmodule

// ===== rtl/aect_parser.sv =====
// Parser state and one-character step logic for the chunk tokenizer.
// Depends on aect_pkg; advances its state when i_step is high.
module aect_parser import aect_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    output t_result    o_result
);

    t_mode                r_mode, n_mode;
    t_len                 r_len, n_len;
    logic                 r_first_zero, n_first_zero;
    logic                 r_text, n_text;
    logic                 r_reset, n_reset;
    logic                 r_title, n_title;
    logic [LINE_BITS-1:0] r_line, n_line;

    logic do_append;
    logic try_close;
    logic close_eol;
    logic set_reset;
    logic set_title;
    logic clear_text;
    logic eff_reset;
    logic eff_title;
    logic close_ok;
    logic [LINE_BITS+LINE_OUT_BITS-1:0] line_ext;

    // next mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_NORMAL: if (i_char == CH_ESC) n_mode = MODE_ESC;
            MODE_ESC: begin
                if (i_char == CH_CSI) begin
                    n_mode = MODE_CSI;
                end else if (i_char == CH_OSC) begin
                    n_mode = MODE_OSC;
                end
            end
            MODE_OSC: if (i_char == CH_BEL) n_mode = MODE_NORMAL;
            MODE_CSI: begin
                if (i_char == CH_SGR || is_csi_final(i_char)) n_mode = MODE_NORMAL;
            end
            default: n_mode = MODE_NORMAL;
        endcase
    end

    // actions
    always_comb begin
        do_append  = 1'b0;
        try_close  = 1'b0;
        close_eol  = 1'b0;
        set_reset  = 1'b0;
        set_title  = 1'b0;
        clear_text = 1'b0;
        unique case (r_mode)
            MODE_NORMAL: begin
                if (i_char == CH_ESC) begin
                    try_close  = 1'b1;
                    clear_text = 1'b1;
                end else if (i_char == CH_LF) begin
                    try_close = 1'b1;
                    close_eol = 1'b1;
                end else if (i_char != CH_CR) begin
                    do_append = 1'b1;
                end
            end
            MODE_ESC: begin
            end
            MODE_OSC: begin
                if (i_char == CH_BEL) begin
                    set_title = 1'b1;
                    try_close = 1'b1;
                    close_eol = 1'b1;
                end else begin
                    do_append = 1'b1;
                end
            end
            MODE_CSI: begin
                if (i_char == CH_SGR) begin
                    set_reset = (r_len == LEN_EMPTY) || (r_len == LEN_ONE && r_first_zero);
                    try_close = 1'b1;
                end else if (is_csi_final(i_char)) begin
                    try_close = 1'b1;
                end else begin
                    do_append = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign eff_reset = r_reset | set_reset;
    assign eff_title = r_title | set_title;
    assign close_ok  = try_close && (eff_reset || r_len != LEN_EMPTY);
    assign line_ext  = {{LINE_OUT_BITS{1'b0}}, r_line};

    // chunk state
    always_comb begin
        n_len        = r_len;
        n_first_zero = r_first_zero;
        n_text       = r_text;
        n_reset      = eff_reset;
        n_title      = eff_title;
        n_line       = r_line;
        if (do_append) begin
            if (r_len == LEN_EMPTY) n_first_zero = (i_char == CH_ZERO);
            if (r_len == LEN_EMPTY) begin
                n_len = LEN_ONE;
            end else begin
                n_len = LEN_MANY;
            end
        end
        if (close_ok) begin
            n_len        = LEN_EMPTY;
            n_first_zero = 1'b0;
            n_text       = 1'b1;
            n_reset      = 1'b0;
            n_title      = 1'b0;
            if (close_eol) n_line = r_line + LINE_BITS'(1);
        end
        if (clear_text) n_text = 1'b0;
    end

    always_comb begin
        o_result                 = '0;
        o_result.append_valid    = do_append;
        o_result.append_char     = do_append ? i_char : 8'h00;
        o_result.chunk_closed    = close_ok;
        if (close_ok) begin
            o_result.closed_is_text  = r_text;
            o_result.closed_is_reset = eff_reset;
            o_result.closed_is_title = eff_title;
            o_result.closed_at_eol   = close_eol;
            o_result.closed_line     = line_ext[LINE_OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_len        <= LEN_EMPTY;
            r_first_zero <= 1'b0;
            r_text       <= 1'b1;
            r_reset      <= 1'b0;
            r_title      <= 1'b0;
            r_line       <= '0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_len        <= n_len;
            r_first_zero <= n_first_zero;
            r_text       <= n_text;
            r_reset      <= n_reset;
            r_title      <= n_title;
            r_line       <= n_line;
        end
    end

endmodule

// ===== sim/aect_checker.sv =====
// Checker for the ANSI escape chunk tokenizer: watches both channels, predicts
// each result from the accepted characters and compares it field by field.
// Depends on aect_pkg for the character codes, mode and length types and t_result.
module aect_checker import aect_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_char,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_result    i_out_result,
    output int         o_fail_count,
    output int         o_open_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PEND_DEPTH = 8;

    t_mode                parse_mode;
    t_len                 data_len;
    logic                 lead_zero;
    logic                 text_mark;
    logic                 reset_mark;
    logic                 title_mark;
    logic [LINE_BITS-1:0] line_num;

    t_result    predicted_beats[PEND_DEPTH];
    logic [2:0] pend_rd;
    logic [2:0] pend_wr;
    int         pend_count;

    task automatic begin_chunk();
        data_len   = LEN_EMPTY;
        lead_zero  = 1'b0;
        text_mark  = 1'b1;
        reset_mark = 1'b0;
        title_mark = 1'b0;
    endtask

    task automatic grow_chunk(input logic [7:0] c, inout t_result r);
        if (data_len == LEN_EMPTY) begin
            lead_zero = (c == CH_ZERO);
        end
        if (data_len != LEN_MANY) begin
            data_len = t_len'(data_len + 2'd1);
        end
        r.append_valid = 1'b1;
        r.append_char  = c;
    endtask

    task automatic close_chunk(input logic eol, inout t_result r);
        if (!reset_mark && data_len == LEN_EMPTY) begin
            return;
        end
        r.chunk_closed    = 1'b1;
        r.closed_is_text  = text_mark;
        r.closed_is_reset = reset_mark;
        r.closed_is_title = title_mark;
        r.closed_at_eol   = eol;
        r.closed_line     = LINE_OUT_BITS'(line_num);
        if (eol) begin
            line_num = line_num + 1'b1;
        end
        begin_chunk();
    endtask

    task automatic tokenize_char(input logic [7:0] c, output t_result r);
        r = '0;
        case (parse_mode)
            MODE_NORMAL: begin
                if (c == CH_ESC) begin
                    close_chunk(1'b0, r);
                    text_mark  = 1'b0;
                    parse_mode = MODE_ESC;
                end else if (c == CH_LF) begin
                    close_chunk(1'b1, r);
                end else if (c != CH_CR) begin
                    grow_chunk(c, r);
                end
            end
            MODE_ESC: begin
                if (c == CH_CSI) begin
                    parse_mode = MODE_CSI;
                end else if (c == CH_OSC) begin
                    parse_mode = MODE_OSC;
                end
            end
            MODE_OSC: begin
                if (c == CH_BEL) begin
                    title_mark = 1'b1;
                    close_chunk(1'b1, r);
                    parse_mode = MODE_NORMAL;
                end else begin
                    grow_chunk(c, r);
                end
            end
            default: begin
                if (c == CH_SGR
                    && (data_len == LEN_EMPTY || (data_len == LEN_ONE && lead_zero))) begin
                    reset_mark = 1'b1;
                end
                case (c)
                    CH_SGR, "K", "A", "B", "C", "D", "E", "F", "G", "H", "J",
                    "S", "T", "f", "i", "n", "u", "s": begin
                        close_chunk(1'b0, r);
                        parse_mode = MODE_NORMAL;
                    end
                    default: grow_chunk(c, r);
                endcase
            end
        endcase
    endtask

    function automatic string show_result(input t_result r);
        return $sformatf({"app=%0b ch=%02h closed=%0b text=%0b reset=%0b title=%0b",
                          " eol=%0b line=%0d"},
                         r.append_valid, r.append_char, r.chunk_closed, r.closed_is_text,
                         r.closed_is_reset, r.closed_is_title, r.closed_at_eol, r.closed_line);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result next_beat;
        logic    bad;
        if (!i_rst_n) begin
            parse_mode = MODE_NORMAL;
            line_num   = '0;
            begin_chunk();
            pend_rd      = '0;
            pend_wr      = '0;
            pend_count   = 0;
            o_fail_count = 0;
            o_open_beats = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pend_count == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: result beat with none pending: %s", $realtime,
                                 show_result(i_out_result));
                    end
                end else begin
                    want       = predicted_beats[pend_rd];
                    pend_rd    = pend_rd + 3'd1;
                    pend_count = pend_count - 1;
                    bad  = (i_out_result.append_valid    !== want.append_valid)
                        || (i_out_result.append_char     !== want.append_char)
                        || (i_out_result.chunk_closed    !== want.chunk_closed)
                        || (i_out_result.closed_is_text  !== want.closed_is_text)
                        || (i_out_result.closed_is_reset !== want.closed_is_reset)
                        || (i_out_result.closed_is_title !== want.closed_is_title)
                        || (i_out_result.closed_at_eol   !== want.closed_at_eol)
                        || (i_out_result.closed_line     !== want.closed_line);
                    if (bad) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                                     show_result(want), show_result(i_out_result));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                tokenize_char(i_in_char, next_beat);
                if (pend_count == PEND_DEPTH) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("%0t: too many beats in flight", $realtime);
                    end
                end else begin
                    predicted_beats[pend_wr] = next_beat;
                    pend_wr    = pend_wr + 3'd1;
                    pend_count = pend_count + 1;
                end
            end
            o_open_beats = pend_count;
        end
    end

endmodule

// ===== sim/tb_ansi_escape_chunk_tokenizer.sv =====
// Testbench top for the ANSI escape chunk tokenizer: clock, reset, character
// stimulus with random gaps and stalls, watchdog and verdict.
// Depends on aect_pkg, ansi_escape_chunk_tokenizer and aect_checker.
module tb_ansi_escape_chunk_tokenizer;
    import aect_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam logic [7:0] DIRECTED_CHARS [26] = '{
        8'h00, 8'hFF, CH_LF,
        CH_ESC, CH_CSI, CH_SGR,
        CH_ESC, CH_CSI, CH_ZERO, CH_SGR,
        CH_ESC, CH_OSC, "a", CH_BEL,
        CH_ESC, CH_OSC, CH_BEL, CH_CR, CH_LF,
        CH_ESC, "x", CH_CSI, "1", "A",
        "z", CH_LF
    };

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic [7:0]               i_data_char = 8'h00;
    logic                     i_ready = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic                     o_append_valid;
    logic [7:0]               o_append_char;
    logic                     o_chunk_closed;
    logic                     o_closed_is_text;
    logic                     o_closed_is_reset;
    logic                     o_closed_is_title;
    logic                     o_closed_at_eol;
    logic [LINE_OUT_BITS-1:0] o_closed_line;

    t_result seen_result;
    int      fail_count;
    int      open_beats;
    int      tx_gap_pct = 0;
    int      rx_stall_pct = 0;
    int      rx_hold = 0;
    int      idle_cycles = 0;
    int      random_chars = 0;
    string   csi_finals = "KABCDEFGHJSTfinusm";

    assign seen_result = {o_append_valid, o_append_char, o_chunk_closed, o_closed_is_text,
                          o_closed_is_reset, o_closed_is_title, o_closed_at_eol, o_closed_line};

    ansi_escape_chunk_tokenizer uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_char       (i_data_char),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_append_valid    (o_append_valid),
        .o_append_char     (o_append_char),
        .o_chunk_closed    (o_chunk_closed),
        .o_closed_is_text  (o_closed_is_text),
        .o_closed_is_reset (o_closed_is_reset),
        .o_closed_is_title (o_closed_is_title),
        .o_closed_at_eol   (o_closed_at_eol),
        .o_closed_line     (o_closed_line)
    );

    aect_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_char    (i_data_char),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_result (seen_result),
        .o_fail_count (fail_count),
        .o_open_beats (open_beats)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_ready = 1'b0;
        end else if ($urandom_range(99) < rx_stall_pct) begin
            rx_hold = $urandom_range(8);
            i_ready = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_char(input logic [7:0] c);
        i_data_char = c;
        i_valid     = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if ($urandom_range(99) < tx_gap_pct) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    task automatic send_random_char(input logic [7:0] c);
        send_char(c);
        random_chars++;
    endtask

    task automatic send_random_sequence();
        int kind;
        int n;
        kind = $urandom_range(9);
        if (kind <= 2) begin
            n = $urandom_range(6);
            repeat (n) begin
                if ($urandom_range(7) == 0) begin
                    send_random_char(8'($urandom_range(255)));
                end else begin
                    send_random_char(8'($urandom_range(8'h20, 8'h7E)));
                end
            end
            case ($urandom_range(3))
                0: send_random_char(CH_LF);
                1: begin
                    send_random_char(CH_CR);
                    send_random_char(CH_LF);
                end
                default: ;
            endcase
        end else if (kind <= 5) begin
            send_random_char(CH_ESC);
            send_random_char(CH_CSI);
            case ($urandom_range(3))
                0: ;
                1: send_random_char(CH_ZERO);
                2: begin
                    send_random_char(CH_ZERO);
                    send_random_char(CH_ZERO);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        send_random_char($urandom_range(1) ? ";" : 8'($urandom_range("0", "9")));
                    end
                end
            endcase
            // leave some sequences open so the next one lands inside them
            if ($urandom_range(9) != 0) begin
                if ($urandom_range(2) == 0) begin
                    send_random_char(CH_SGR);
                end else begin
                    send_random_char(csi_finals[$urandom_range(csi_finals.len() - 1)]);
                end
            end
        end else if (kind <= 7) begin
            send_random_char(CH_ESC);
            send_random_char(CH_OSC);
            repeat ($urandom_range(5)) send_random_char(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(9) != 0) begin
                send_random_char(CH_BEL);
            end
        end else if (kind == 8) begin
            send_random_char(CH_ESC);
            send_random_char(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 4)) send_random_char(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_results_drained();
        while (open_beats != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        foreach (DIRECTED_CHARS[k]) send_char(DIRECTED_CHARS[k]);

        // hold the sender until every pending result is out
        i_valid = 1'b0;
        wait_results_drained();

        while (random_chars < 300) begin
            if ($urandom_range(15) == 0) begin
                tx_gap_pct   = $urandom_range(1) ? 0 : $urandom_range(10, 50);
                rx_stall_pct = $urandom_range(1) ? 0 : $urandom_range(10, 50);
            end
            send_random_sequence();
        end

        // drop idling for the last part
        tx_gap_pct   = 0;
        rx_stall_pct = 0;

        while (random_chars < 400) send_random_sequence();

        i_valid = 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
